FILE: rtl/tty_line_discipline_unit_defines.svh
// Assertion macros used by the line discipline datapath.
`ifndef TTY_LINE_DISCIPLINE_UNIT_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define TLDU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define TLDU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/tldu_pkg.sv
// Types and constants of the terminal line discipline unit.
`default_nettype none

package tldu_pkg;

  typedef enum logic [1:0] {
    ROUTE_ECHO = 2'd0,
    ROUTE_READ = 2'd1,
    ROUTE_SIG  = 2'd2
  } route_t;

  typedef enum logic [2:0] {
    CFG_MODE  = 3'd0,
    CFG_INTR  = 3'd1,
    CFG_QUIT  = 3'd2,
    CFG_ERASE = 3'd3,
    CFG_KILL  = 3'd4,
    CFG_EOF   = 3'd5,
    CFG_SUSP  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_BYTE  = 2'd1,
    SRC_STORE = 2'd2
  } src_t;

  typedef enum logic [2:0] {
    LEN_HOLD      = 3'd0,
    LEN_PUSH_BYTE = 3'd1,
    LEN_PUSH_NL   = 3'd2,
    LEN_DEC       = 3'd3,
    LEN_CLEAR     = 3'd4
  } len_op_t;

  // mode flag bits
  localparam int unsigned FLAG_ECHO  = 0;
  localparam int unsigned FLAG_CANON = 1;
  localparam int unsigned FLAG_SIG   = 2;

  localparam logic [2:0] RST_MODE  = 3'd7;
  localparam logic [7:0] RST_INTR  = 8'd3;
  localparam logic [7:0] RST_QUIT  = 8'd28;
  localparam logic [7:0] RST_ERASE = 8'h7F;
  localparam logic [7:0] RST_KILL  = 8'd21;
  localparam logic [7:0] RST_EOF   = 8'd4;
  localparam logic [7:0] RST_SUSP  = 8'd26;

  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [7:0] SIG_INTR = 8'd0;
  localparam logic [7:0] SIG_QUIT = 8'd1;
  localparam logic [7:0] SIG_SUSP = 8'd2;

  typedef struct packed {
    logic       accept;
    len_op_t    len_op;
    logic       idx_inc;
    logic       out_load;
    route_t     route;
    src_t       src;
    logic [7:0] const_byte;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic echo;
    logic canon;
    logic sig_en;
    logic is_intr;
    logic is_quit;
    logic is_susp;
    logic is_erase;
    logic is_kill;
    logic is_nlcr;
    logic is_eof;
    logic len_zero;
    logic len_one;
    logic line_full;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/tty_line_discipline_unit.sv
// Top level of the terminal line discipline unit.
//
//   channel  direction  handshake              payload
//   in_*     input      in_tvalid/in_tready    in_tdata = typed byte
//   out_*    output     out_tvalid/out_tready  out_tdata = byte, out_tuser = route,
//                                              out_tlast = final result of the byte
//   cfg_*    input      cfg_we                 cfg_index, cfg_wdata
//
// An item is taken while the controller is idle; each of its N results then passes
// through the single output register, with N up to 3*(LINE_DEPTH-1) for a kill of
// a full line (rubouts sequenced by the controller).
// The next item is taken while the final result still waits in the output register.
// Reset is synchronous; it clears the line length and loads the register defaults.
// The line store needs no clearing pass. out_tready low holds the sequencer while a result waits.
`default_nettype none

module tty_line_discipline_unit
  import tldu_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] data_byte
  output logic [1:0]      out_tuser,  // [1:0] route
  output logic            out_tlast
);

  cmd_t    cmd;
  status_t st;

  tldu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tldu_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/tldu_dp.sv
// Datapath: configuration registers, byte decode, line store and output register.
`default_nettype none
`include "tty_line_discipline_unit_defines.svh"

module tldu_dp
  import tldu_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic [7:0] in_tdata,
  input  wire cmd_t       cmd,
  output status_t         st,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic [1:0]      out_tuser,
  output logic            out_tlast
);

  localparam int unsigned LW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned IW = $clog2(LINE_DEPTH);

  logic [2:0] mode_r;
  logic [7:0] intr_r, quit_r, erase_r, kill_r, eof_r, susp_r;

  logic [7:0]    store_r [LINE_DEPTH];
  logic [LW-1:0] len_r, len_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [7:0]    byte_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  route_t     out_route_r;
  logic       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= RST_MODE;
      intr_r  <= RST_INTR;
      quit_r  <= RST_QUIT;
      erase_r <= RST_ERASE;
      kill_r  <= RST_KILL;
      eof_r   <= RST_EOF;
      susp_r  <= RST_SUSP;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:  mode_r  <= cfg_wdata[2:0];
        CFG_INTR:  intr_r  <= cfg_wdata;
        CFG_QUIT:  quit_r  <= cfg_wdata;
        CFG_ERASE: erase_r <= cfg_wdata;
        CFG_KILL:  kill_r  <= cfg_wdata;
        CFG_EOF:   eof_r   <= cfg_wdata;
        CFG_SUSP:  susp_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    st.echo      = mode_r[FLAG_ECHO];
    st.canon     = mode_r[FLAG_CANON];
    st.sig_en    = mode_r[FLAG_SIG];
    st.is_intr   = (in_tdata == intr_r);
    st.is_quit   = (in_tdata == quit_r);
    st.is_susp   = (in_tdata == susp_r);
    st.is_erase  = (in_tdata == erase_r);
    st.is_kill   = (in_tdata == kill_r);
    st.is_nlcr   = (in_tdata == CH_NL) || (in_tdata == CH_CR);
    st.is_eof    = (in_tdata == eof_r);
    st.len_zero  = (len_r == '0);
    st.len_one   = (len_r == LW'(1));
    st.line_full = (len_r >= LW'(LINE_DEPTH - 1));
    st.idx_last  = ((LW'(idx_r) + LW'(1)) == len_r);
    st.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    len_nxt = len_r;
    unique case (cmd.len_op)
      LEN_HOLD:      len_nxt = len_r;
      LEN_PUSH_BYTE,
      LEN_PUSH_NL:   len_nxt = len_r + LW'(1);
      LEN_DEC:       len_nxt = len_r - LW'(1);
      LEN_CLEAR:     len_nxt = '0;
      default:       len_nxt = len_r;
    endcase
    idx_nxt = idx_r;
    if (cmd.idx_inc) begin
      idx_nxt = st.idx_last ? '0 : idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      idx_r <= '0;
    end else begin
      len_r <= len_nxt;
      idx_r <= idx_nxt;
    end
  end

  // length never passes LINE_DEPTH-1 before a push, so it indexes the store directly
  always_ff @(posedge clk) begin
    if (cmd.len_op == LEN_PUSH_BYTE) begin
      store_r[len_r[IW-1:0]] <= in_tdata;
    end else if (cmd.len_op == LEN_PUSH_NL) begin
      store_r[len_r[IW-1:0]] <= CH_NL;
    end
    if (cmd.accept) begin
      byte_r <= in_tdata;
    end
  end

  always_comb begin
    unique case (cmd.src)
      SRC_CONST: out_data_nxt = cmd.const_byte;
      SRC_BYTE:  out_data_nxt = byte_r;
      SRC_STORE: out_data_nxt = store_r[idx_r];
      default:   out_data_nxt = cmd.const_byte;
    endcase
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r  <= out_data_nxt;
      out_route_r <= cmd.route;
      out_last_r  <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_route_r;
  assign out_tlast  = out_last_r;

  `TLDU_ASSERT(a_len_bound, len_r <= LW'(LINE_DEPTH), "line length beyond store depth")
  `TLDU_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_r || out_tready), "untaken item overwritten")
  `TLDU_ASSERT(a_idx_in_line, (cmd.out_load && cmd.src == SRC_STORE) |-> (LW'(idx_r) < len_r), "delivery past line end")
  `TLDU_ASSERT_NEXT(a_line_cleared, cmd.idx_inc && st.idx_last, (len_r == '0) && (idx_r == '0), "line not cleared after delivery")

endmodule

`default_nettype wire

FILE: rtl/tldu_ctrl.sv
// Controller: sequences the results of one typed byte, one per cycle while the output register is free.
`default_nettype none

module tldu_ctrl
  import tldu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire status_t st,
  output cmd_t         cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SIG   = 12'b0000_0000_0010,
    S_CARET = 12'b0000_0000_0100,
    S_CCHR  = 12'b0000_0000_1000,
    S_NLEC  = 12'b0000_0001_0000,
    S_RAWRD = 12'b0000_0010_0000,
    S_RAWEC = 12'b0000_0100_0000,
    S_ORDEC = 12'b0000_1000_0000,
    S_BS1   = 12'b0001_0000_0000,
    S_SP    = 12'b0010_0000_0000,
    S_BS2   = 12'b0100_0000_0000,
    S_DELIV = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    K_INTR  = 3'd0,
    K_QUIT  = 3'd1,
    K_SUSP  = 3'd2,
    K_ERASE = 3'd3,
    K_KILL  = 3'd4,
    K_OTHER = 3'd5
  } kind_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          kind_nxt   = K_OTHER;
          priority if (st.sig_en && st.is_intr) begin
            kind_nxt  = K_INTR;
            state_nxt = S_SIG;
            if (st.canon) cmd.len_op = LEN_CLEAR;
          end else if (st.sig_en && st.is_quit) begin
            kind_nxt  = K_QUIT;
            state_nxt = S_SIG;
          end else if (st.sig_en && st.is_susp) begin
            kind_nxt  = K_SUSP;
            state_nxt = S_SIG;
          end else if (!st.canon) begin
            state_nxt = S_RAWRD;
          end else if (st.is_erase) begin
            kind_nxt = K_ERASE;
            if (!st.len_zero) begin
              if (st.echo) state_nxt = S_BS1;
              else cmd.len_op = LEN_DEC;
            end
          end else if (st.is_kill) begin
            kind_nxt = K_KILL;
            if (!st.len_zero) begin
              if (st.echo) state_nxt = S_BS1;
              else cmd.len_op = LEN_CLEAR;
            end
          end else if (st.is_nlcr || st.is_eof) begin
            // a newline that is also the EOF character adds nothing to the line
            if (!st.is_eof) cmd.len_op = LEN_PUSH_NL;
            if (st.echo && st.is_nlcr) state_nxt = S_NLEC;
            else if (!st.is_eof || !st.len_zero) state_nxt = S_DELIV;
          end else begin
            // a full line drops the byte silently
            if (!st.line_full) begin
              cmd.len_op = LEN_PUSH_BYTE;
              if (st.echo) state_nxt = S_ORDEC;
            end
          end
        end
      end
      S_SIG: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.route    = ROUTE_SIG;
          cmd.src      = SRC_CONST;
          unique case (kind_r)
            K_QUIT:  cmd.const_byte = SIG_QUIT;
            K_SUSP:  cmd.const_byte = SIG_SUSP;
            default: cmd.const_byte = SIG_INTR;
          endcase
          cmd.last  = (kind_r != K_INTR) || !st.echo;
          state_nxt = cmd.last ? S_IDLE : S_CARET;
        end
      end
      S_CARET: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.const_byte = CH_CARET;
          state_nxt      = S_CCHR;
        end
      end
      S_CCHR: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.const_byte = CH_C;
          state_nxt      = S_NLEC;
        end
      end
      S_NLEC: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.const_byte = CH_NL;
          cmd.last       = (kind_r == K_INTR) || st.len_zero;
          state_nxt      = cmd.last ? S_IDLE : S_DELIV;
        end
      end
      S_RAWRD: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.route    = ROUTE_READ;
          cmd.src      = SRC_BYTE;
          cmd.last     = !st.echo;
          state_nxt    = st.echo ? S_RAWEC : S_IDLE;
        end
      end
      S_RAWEC, S_ORDEC: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.src      = SRC_BYTE;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_BS1: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.const_byte = CH_BS;
          state_nxt      = S_SP;
        end
      end
      S_SP: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.const_byte = CH_SPACE;
          state_nxt      = S_BS2;
        end
      end
      S_BS2: begin
        // one stored byte is dropped per rubout
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.const_byte = CH_BS;
          cmd.len_op     = LEN_DEC;
          cmd.last       = (kind_r == K_ERASE) || st.len_one;
          state_nxt      = cmd.last ? S_IDLE : S_BS1;
        end
      end
      S_DELIV: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.route    = ROUTE_READ;
          cmd.src      = SRC_STORE;
          cmd.idx_inc  = 1'b1;
          cmd.last     = st.idx_last;
          if (st.idx_last) begin
            cmd.len_op = LEN_CLEAR;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_OTHER;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

`default_nettype wire
